>>> hw/rtl/bpfs_pkg.sv
// Shared types, constants and lookup tables of the Blinn-Phong fragment shading core.
package bpfs_pkg;

  localparam int unsigned SQRT_STAGES = 28;
  localparam int unsigned DIV_STAGES  = 17;
  localparam int unsigned POW_STAGES  = 7;
  localparam int unsigned LATENCY     = 65;

  localparam logic [32:0] POW_CAP = 33'h1_0000_0000;
  localparam logic [32:0] POW_LIM = 33'h0_0100_0000;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  typedef enum logic [2:0] {
    REG_LIGHT_RED   = 3'd0,
    REG_LIGHT_GREEN = 3'd1,
    REG_LIGHT_BLUE  = 3'd2,
    REG_LIGHT_DIR_X = 3'd3,
    REG_LIGHT_DIR_Y = 3'd4,
    REG_LIGHT_DIR_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]         texel_red;
    logic [7:0]         texel_green;
    logic [7:0]         texel_blue;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [23:0] view_x;
    logic signed [23:0] view_y;
    logic signed [23:0] view_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  typedef struct packed {
    logic [2:0][7:0] texel;
    logic [18:0]     d14;
  } side_t;

  typedef struct packed {
    logic [55:0] len2;
    logic [43:0] dns;
    side_t       side;
  } geo_res_t;

  typedef struct packed {
    logic [27:0] len;
    logic [43:0] dns;
    side_t       side;
  } root_res_t;

  typedef struct packed {
    logic [32:0] spow;
    side_t       side;
  } spec_res_t;

  typedef struct packed {
    logic [63:0]        m;
    logic signed [31:0] e;
  } pf_t;

  function automatic pf_t pf_from_q16(input logic [63:0] v);
    pf_t         r;
    logic [63:0] x;
    int          sh;
    x = v;
    sh = 0;
    r.m = '0;
    r.e = '0;
    if (x != '0) begin
      while (x < 64'h8000_0000) begin
        x = x << 1;
        sh = sh + 1;
      end
      r.m = x;
      r.e = 32'(-sh - 16);
    end
    return r;
  endfunction

  function automatic pf_t pf_mul(input pf_t a, input pf_t b);
    pf_t         r;
    logic [63:0] p;
    r.m = '0;
    r.e = '0;
    if (a.m != '0 && b.m != '0) begin
      p = a.m * b.m;
      if (p[63]) begin
        r.m = p >> 32;
        r.e = a.e + b.e + 32'sd32;
      end else begin
        r.m = p >> 31;
        r.e = a.e + b.e + 32'sd31;
      end
    end
    return r;
  endfunction

  function automatic pf_t pf_pow(input pf_t a, input int unsigned n);
    pf_t r;
    r.m = 64'h8000_0000;
    r.e = -32'sd31;
    for (int unsigned i = 0; i < n; i++) begin
      r = pf_mul(r, a);
    end
    return r;
  endfunction

  function automatic logic pf_le(input pf_t a, input pf_t b);
    if (a.m == '0) return 1'b1;
    if (b.m == '0) return 1'b0;
    if (a.e != b.e) return a.e < b.e;
    return a.m <= b.m;
  endfunction

  function automatic logic [16:0] frac_power(input logic [63:0] x, input int unsigned num,
                                             input int unsigned den);
    pf_t         tgt;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    tgt = pf_pow(pf_from_q16(x), num);
    lo = '0;
    hi = 64'd65536;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pf_le(pf_pow(pf_from_q16(mid), den), tgt)) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo[16:0];
  endfunction

  typedef logic [16:0] alb_lut_t [256];
  typedef logic [17:0] gam_lut_t [256];

  function automatic alb_lut_t gen_albedo_lut();
    alb_lut_t    t;
    logic [63:0] x;
    for (int i = 0; i < 256; i++) begin
      x = (64'(i) * 64'd65536 + 64'd127) / 64'd255;
      t[i] = frac_power(x, 11, 5);
    end
    return t;
  endfunction

  // Entry k is the smallest linear shade whose encoded byte is at least k.
  function automatic gam_lut_t gen_gamma_lut();
    gam_lut_t    t;
    logic [63:0] yk;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    pf_t         tgt;
    t[0] = '0;
    for (int k = 1; k < 256; k++) begin
      yk = (64'(k) * 64'd65536 - 64'd32768 + 64'd254) / 64'd255;
      tgt = pf_pow(pf_from_q16(yk), 20);
      lo = '0;
      hi = 64'd65537;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (mid <= 64'd65536 && pf_le(tgt, pf_pow(pf_from_q16(mid), 9))) hi = mid;
        else lo = mid + 64'd1;
      end
      t[k] = lo[17:0];
    end
    return t;
  endfunction

  localparam alb_lut_t ALBEDO_LUT = gen_albedo_lut();
  localparam gam_lut_t GAMMA_LUT  = gen_gamma_lut();

  function automatic logic [7:0] gamma_step(input logic [7:0] k, input logic [16:0] s,
                                            input int unsigned bitpos);
    logic [7:0] cand;
    cand = k | (8'd1 << bitpos);
    if ({1'b0, s} >= GAMMA_LUT[cand]) return cand;
    return k;
  endfunction

endpackage

>>> hw/rtl/bpfs_geom.sv
// Front stages: light and half-vector setup, dot products and squared length.
module bpfs_geom (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  bpfs_pkg::in_item_t  item_i,
  input  logic signed [15:0]  dir_x_i,
  input  logic signed [15:0]  dir_y_i,
  input  logic signed [15:0]  dir_z_i,
  output logic                valid_o,
  output bpfs_pkg::geo_res_t  res_o
);

  logic               a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  bpfs_pkg::in_item_t a_item_q;
  logic signed [15:0] dir [3];
  logic signed [15:0] n_a [3];
  logic signed [23:0] v_a [3];
  logic signed [16:0] l_d [3];
  logic signed [16:0] l_q [3];
  logic signed [26:0] s_d [3];
  logic signed [26:0] s_q [3];
  logic signed [15:0] n_q [3];
  logic signed [32:0] ln_d [3];
  logic signed [32:0] ln_q [3];
  logic signed [42:0] ns_d [3];
  logic signed [42:0] ns_q [3];
  logic signed [53:0] ss_d [3];
  logic signed [53:0] ss_q [3];
  bpfs_pkg::side_t    b_side_d, b_side_q, c_side_q;
  logic signed [34:0] dln;
  logic signed [44:0] dns;
  logic [55:0]        len2;
  bpfs_pkg::geo_res_t d_res_d, d_res_q;

  always_comb begin
    dir = '{dir_x_i, dir_y_i, dir_z_i};
    n_a = '{a_item_q.normal_x, a_item_q.normal_y, a_item_q.normal_z};
    v_a = '{a_item_q.view_x, a_item_q.view_y, a_item_q.view_z};
    for (int i = 0; i < 3; i++) begin
      l_d[i] = 17'sd0 - 17'(dir[i]);
      s_d[i] = 27'(l_d[i]) - (27'(v_a[i]) <<< 2);
    end
    b_side_d.texel[0] = a_item_q.texel_red;
    b_side_d.texel[1] = a_item_q.texel_green;
    b_side_d.texel[2] = a_item_q.texel_blue;
    b_side_d.d14 = '0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ln_d[i] = l_q[i] * n_q[i];
      ns_d[i] = n_q[i] * s_q[i];
      ss_d[i] = s_q[i] * s_q[i];
    end
  end

  always_comb begin
    dln = 35'(ln_q[0]) + 35'(ln_q[1]) + 35'(ln_q[2]);
    dns = 45'(ns_q[0]) + 45'(ns_q[1]) + 45'(ns_q[2]);
    len2 = 56'(ss_q[0]) + 56'(ss_q[1]) + 56'(ss_q[2]);
    d_res_d.len2 = len2;
    d_res_d.side.texel = c_side_q.texel;
    d_res_d.side.d14 = (dln > 35'sd0) ? 19'((dln + 35'sd8192) >>> 14) : '0;
    d_res_d.dns = (len2 == '0 || dns <= 45'sd0) ? '0 : dns[43:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_item_q <= item_i;
    b_side_q <= b_side_d;
    c_side_q <= b_side_q;
    d_res_q <= d_res_d;
    for (int i = 0; i < 3; i++) begin
      l_q[i] <= l_d[i];
      s_q[i] <= s_d[i];
      n_q[i] <= n_a[i];
      ln_q[i] <= ln_d[i];
      ns_q[i] <= ns_d[i];
      ss_q[i] <= ss_d[i];
    end
  end

  assign valid_o = d_valid_q;
  assign res_o = d_res_q;

endmodule

>>> hw/rtl/bpfs_sqrt.sv
// Pipelined integer square root of the half-vector squared length, one result bit per stage.
module bpfs_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  bpfs_pkg::geo_res_t  res_i,
  output logic                valid_o,
  output bpfs_pkg::root_res_t res_o
);

  localparam int unsigned N = bpfs_pkg::SQRT_STAGES;

  logic            vld_q  [N+1];
  logic [55:0]     rem_q  [N+1];
  logic [55:0]     root_q [N+1];
  logic [43:0]     dns_q  [N+1];
  bpfs_pkg::side_t side_q [N+1];

  assign vld_q[0] = valid_i;
  assign rem_q[0] = res_i.len2;
  assign root_q[0] = '0;
  assign dns_q[0] = res_i.dns;
  assign side_q[0] = res_i.side;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic [55:0] StepBit = 56'(1) << (2 * (N - 1 - j));
    logic [55:0] trial;
    logic        take;

    assign trial = root_q[j] + StepBit;
    assign take = rem_q[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= take ? rem_q[j] - trial : rem_q[j];
      root_q[j+1] <= take ? (root_q[j] >> 1) + StepBit : root_q[j] >> 1;
      dns_q[j+1] <= dns_q[j];
      side_q[j+1] <= side_q[j];
    end
  end

  assign valid_o = vld_q[N];
  assign res_o.len = root_q[N][27:0];
  assign res_o.dns = dns_q[N];
  assign res_o.side = side_q[N];

endmodule

>>> hw/rtl/bpfs_spec.sv
// Pipelined cosine divider followed by the seven squaring stages of the specular power.
module bpfs_spec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  bpfs_pkg::root_res_t res_i,
  output logic                valid_o,
  output bpfs_pkg::spec_res_t res_o
);

  localparam int unsigned ND = bpfs_pkg::DIV_STAGES;
  localparam int unsigned NP = bpfs_pkg::POW_STAGES;

  logic            dvld_q  [ND+1];
  logic [43:0]     drem_q  [ND+1];
  logic [16:0]     quo_q   [ND+1];
  logic [27:0]     dlen_q  [ND+1];
  bpfs_pkg::side_t dside_q [ND+1];
  logic            pvld_q  [NP+1];
  logic [32:0]     pc_q    [NP+1];
  bpfs_pkg::side_t pside_q [NP+1];

  assign dvld_q[0] = valid_i;
  assign drem_q[0] = res_i.dns;
  assign quo_q[0] = '0;
  assign dlen_q[0] = (res_i.len == '0) ? 28'd1 : res_i.len;
  assign dside_q[0] = res_i.side;

  for (genvar j = 0; j < ND; j++) begin : g_div
    localparam int unsigned Sh = ND - 1 - j;
    logic [43:0] sub;
    logic        take;

    assign sub = 44'(dlen_q[j]) << Sh;
    assign take = drem_q[j] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[j+1] <= 1'b0;
      end else begin
        dvld_q[j+1] <= dvld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      drem_q[j+1] <= take ? drem_q[j] - sub : drem_q[j];
      quo_q[j+1] <= take ? (quo_q[j] | (17'd1 << Sh)) : quo_q[j];
      dlen_q[j+1] <= dlen_q[j];
      dside_q[j+1] <= dside_q[j];
    end
  end

  assign pvld_q[0] = dvld_q[ND];
  assign pc_q[0] = 33'(quo_q[ND]) << 2;
  assign pside_q[0] = dside_q[ND];

  for (genvar i = 0; i < NP; i++) begin : g_pow
    logic [47:0] sq;

    assign sq = 48'(pc_q[i][23:0]) * 48'(pc_q[i][23:0]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pvld_q[i+1] <= 1'b0;
      end else begin
        pvld_q[i+1] <= pvld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      pc_q[i+1] <= (pc_q[i] >= bpfs_pkg::POW_LIM) ? bpfs_pkg::POW_CAP :
                   33'((sq + 48'd32768) >> 16);
      pside_q[i+1] <= pside_q[i];
    end
  end

  assign valid_o = pvld_q[NP];
  assign res_o.spow = pc_q[NP];
  assign res_o.side = pside_q[NP];

endmodule

>>> hw/rtl/bpfs_color.sv
// Per-channel shading: albedo lookup, ambient, diffuse and specular terms, gamma encoding.
module bpfs_color (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  bpfs_pkg::spec_res_t res_i,
  input  logic [15:0]         light_red_i,
  input  logic [15:0]         light_green_i,
  input  logic [15:0]         light_blue_i,
  output logic                valid_o,
  output bpfs_pkg::out_item_t result_o
);

  logic [8:0]  vld_q;
  logic [15:0] light [3];
  logic [16:0] alb_d [3], alb_q [3];
  logic [37:0] spe_d [3], spe1_q [3], spe2_q [3], spe3_q [3], spe4_q [3];
  logic [16:0] amb_d [3], amb2_q [3], amb3_q [3], amb4_q [3];
  logic [20:0] u0_d [3], u0_q [3];
  logic [18:0] u_d [3], u_q [3];
  logic [25:0] dif_d [3], dif_q [3];
  logic [39:0] tot [3];
  logic [16:0] sum_d [3], sum_q [3];
  logic [18:0] d14_1_q, d14_2_q, d14_3_q;
  logic [7:0]  k_d [4][3];
  logic [7:0]  k_q [4][3];
  logic [16:0] gsum_q [3][3];

  assign light = '{light_red_i, light_green_i, light_blue_i};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      alb_d[c] = bpfs_pkg::ALBEDO_LUT[res_i.side.texel[c]];
      spe_d[c] = 38'((50'(light[c]) * 50'(res_i.spow) + 50'd2048) >> 12);
      amb_d[c] = 17'((33'(alb_q[c]) * 33'd52429 + 33'd32768) >> 16);
      u0_d[c] = 21'((34'(alb_q[c]) * 34'(light[c]) + 34'd2048) >> 12);
      u_d[c] = 19'((35'(u0_q[c]) * 35'd13107 + 35'd32768) >> 16);
      dif_d[c] = 26'((40'(u_q[c]) * 40'(d14_3_q) + 40'd8192) >> 14);
      tot[c] = 40'(amb4_q[c]) + 40'(dif_q[c]) + 40'(spe4_q[c]);
      sum_d[c] = (tot[c] > 40'(bpfs_pkg::ONE_Q16)) ? bpfs_pkg::ONE_Q16 : tot[c][16:0];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_gamma0
    assign k_d[0][c] = bpfs_pkg::gamma_step(bpfs_pkg::gamma_step(8'd0, sum_q[c], 7),
                                            sum_q[c], 6);
  end

  for (genvar g = 1; g < 4; g++) begin : g_gamma
    for (genvar c = 0; c < 3; c++) begin : g_chan
      assign k_d[g][c] = bpfs_pkg::gamma_step(
          bpfs_pkg::gamma_step(k_q[g-1][c], gsum_q[g-1][c], 7 - 2 * g),
          gsum_q[g-1][c], 6 - 2 * g);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    d14_1_q <= res_i.side.d14;
    d14_2_q <= d14_1_q;
    d14_3_q <= d14_2_q;
    for (int c = 0; c < 3; c++) begin
      alb_q[c] <= alb_d[c];
      spe1_q[c] <= spe_d[c];
      amb2_q[c] <= amb_d[c];
      u0_q[c] <= u0_d[c];
      spe2_q[c] <= spe1_q[c];
      u_q[c] <= u_d[c];
      amb3_q[c] <= amb2_q[c];
      spe3_q[c] <= spe2_q[c];
      amb4_q[c] <= amb3_q[c];
      spe4_q[c] <= spe3_q[c];
      dif_q[c] <= dif_d[c];
      sum_q[c] <= sum_d[c];
      gsum_q[0][c] <= sum_q[c];
      gsum_q[1][c] <= gsum_q[0][c];
      gsum_q[2][c] <= gsum_q[1][c];
      for (int g = 0; g < 4; g++) begin
        k_q[g][c] <= k_d[g][c];
      end
    end
  end

  assign valid_o = vld_q[8];
  assign result_o.out_red = k_q[3][0];
  assign result_o.out_green = k_q[3][1];
  assign result_o.out_blue = k_q[3][2];

endmodule

>>> hw/rtl/blinn_phong_fragment_shade_core.sv
// Blinn-Phong fragment shading core with power-2.2 texel linearization and gamma encoding.
// Pipeline: geometry, the 28-stage square root, the 17-stage cosine divider, the specular
// squaring stages and the colour stages, in that order; the square root and the divider
// make up most of the pipeline depth.
// Throughput: one item per cycle; busy stays low and configuration writes are always ready.
// Reset clears every valid bit and loads the default white light pointing down -z.
module blinn_phong_fragment_shade_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bpfs_pkg::in_item_t  item_i,
  output logic                out_valid_o,
  output bpfs_pkg::out_item_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  logic [15:0]         light_red_q, light_green_q, light_blue_q;
  logic [15:0]         light_dir_x_q, light_dir_y_q, light_dir_z_q;
  logic                geo_valid, root_valid, spec_valid;
  bpfs_pkg::geo_res_t  geo_res;
  bpfs_pkg::root_res_t root_res;
  bpfs_pkg::spec_res_t spec_res;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_red_q <= 16'd4096;
      light_green_q <= 16'd4096;
      light_blue_q <= 16'd4096;
      light_dir_x_q <= 16'h0000;
      light_dir_y_q <= 16'h0000;
      light_dir_z_q <= 16'hC000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bpfs_pkg::REG_LIGHT_RED: light_red_q <= cfg_data_i;
        bpfs_pkg::REG_LIGHT_GREEN: light_green_q <= cfg_data_i;
        bpfs_pkg::REG_LIGHT_BLUE: light_blue_q <= cfg_data_i;
        bpfs_pkg::REG_LIGHT_DIR_X: light_dir_x_q <= cfg_data_i;
        bpfs_pkg::REG_LIGHT_DIR_Y: light_dir_y_q <= cfg_data_i;
        bpfs_pkg::REG_LIGHT_DIR_Z: light_dir_z_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bpfs_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .dir_x_i (light_dir_x_q),
    .dir_y_i (light_dir_y_q),
    .dir_z_i (light_dir_z_q),
    .valid_o (geo_valid),
    .res_o   (geo_res)
  );

  bpfs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geo_valid),
    .res_i   (geo_res),
    .valid_o (root_valid),
    .res_o   (root_res)
  );

  bpfs_spec u_spec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (root_valid),
    .res_i   (root_res),
    .valid_o (spec_valid),
    .res_o   (spec_res)
  );

  bpfs_color u_color (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (spec_valid),
    .res_i         (spec_res),
    .light_red_i   (light_red_q),
    .light_green_i (light_green_q),
    .light_blue_i  (light_blue_q),
    .valid_o       (out_valid_o),
    .result_o      (result_o)
  );

endmodule

>>> hw/rtl/bpfs_checker.sv
// Port-level checks of the shading core and the bind that attaches them.
module bpfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input bpfs_pkg::in_item_t  item_i,
  input logic                out_valid_o,
  input bpfs_pkg::out_item_t result_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o
);

  localparam int unsigned Lat = bpfs_pkg::LATENCY;

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat out_valid_o)
    else $error("accepted item produced no result");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy, Lat))
    else $error("result without a matching accepted item");

  a_black_unlit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.texel_red == 8'd0 && item_i.texel_green == 8'd0 &&
     item_i.texel_blue == 8'd0 && item_i.normal_x == 16'sd0 &&
     item_i.normal_y == 16'sd0 && item_i.normal_z == 16'sd0)
    |-> ##Lat (result_o == '0))
    else $error("black texel with zero normal did not shade to black");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write was held off");

endmodule

bind blinn_phong_fragment_shade_core bpfs_checker u_bpfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .out_valid_o (out_valid_o),
  .result_o    (result_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
